/* rtl/core/circle_segment_collide_resolve_top_assert.svh */
// assertion macros for the circle segment collide resolve top level
// expects clk and rst_n in the scope that uses them
`ifndef CIRCLE_SEGMENT_COLLIDE_RESOLVE_TOP_ASSERT_SVH
`define CIRCLE_SEGMENT_COLLIDE_RESOLVE_TOP_ASSERT_SVH

// condition must hold in the same cycle
`define CSCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define CSCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cscr_pkg.sv */
// shared types, register codes and saturation helper for the ball/segment block
// no dependencies
`default_nettype none

package cscr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [REG_IDX_W-1:0] REG_START_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TANGENT_X    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TANGENT_Y    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RESTITUTION  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SLIDE_ASSIST = 3'd7;

  // reset tangent is 1.0 along x
  localparam logic signed [17:0] TAN_X_RST = 18'sd65536;

  // square root pipeline
  localparam int SQRT_STEPS = 27;
  localparam int DSQ_W = 55;

  // saturation to signed 32 bits from a wide intermediate
  localparam int SAT_W = 80;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [17:0] tan_x;
    logic signed [17:0] tan_y;
    logic [16:0]        restitution;
    logic [26:0]        slide_assist;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [26:0]        radius;
  } ball_t;

  typedef struct packed {
    logic short_seg;
    logic t_zero;
    logic t_one;
  } proj_flag_t;

  typedef struct packed {
    logic               hit;
    logic [26:0]        pen;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } contact_t;

  typedef struct packed {
    contact_t           c;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) return 32'sh7fffffff;
    if (v < SAT_LO) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cscr_proj.sv */
// projection of the ball centre onto the segment: dot products and a
// one-bit-per-stage restoring divider giving the clamped parameter t; uses cscr_pkg
`default_nettype none

module cscr_proj #(
  parameter int FRAC_BITS = cscr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  cscr_pkg::ball_t       ball_i,
  input  cscr_pkg::cfg_t        cfg_i,
  output logic                  vld_o,
  output cscr_pkg::ball_t       ball_o,
  output logic [FRAC_BITS:0]    t_o,
  output logic                  short_o
);
  import cscr_pkg::*;

  localparam int LEN_W = 62;
  localparam logic [LEN_W-1:0] SEG_EPS =
    LEN_W'((64'd1 << (2 * FRAC_BITS - 4)) / 64'd10000);

  // stage 1: segment and offset vectors, quartered
  logic signed [32:0] sx, sy, ox, oy;
  logic signed [30:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  ball_t              s1_ball_r;
  logic               s1_vld_r;

  assign sx = {cfg_i.end_x[31], cfg_i.end_x} - {cfg_i.start_x[31], cfg_i.start_x};
  assign sy = {cfg_i.end_y[31], cfg_i.end_y} - {cfg_i.start_y[31], cfg_i.start_y};
  assign ox = {ball_i.pos_x[31], ball_i.pos_x} - {cfg_i.start_x[31], cfg_i.start_x};
  assign oy = {ball_i.pos_y[31], ball_i.pos_y} - {cfg_i.start_y[31], cfg_i.start_y};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r    <= sx[32:2];
      s1_b_r    <= sy[32:2];
      s1_c_r    <= ox[32:2];
      s1_d_r    <= oy[32:2];
      s1_ball_r <= ball_i;
    end
  end

  // stage 2: the four products
  logic signed [61:0] aa, bb, ca, db;
  logic [60:0]        s2_aa_r, s2_bb_r;
  logic signed [61:0] s2_ca_r, s2_db_r;
  ball_t              s2_ball_r;
  logic               s2_vld_r;

  assign aa = s1_a_r * s1_a_r;
  assign bb = s1_b_r * s1_b_r;
  assign ca = s1_c_r * s1_a_r;
  assign db = s1_d_r * s1_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_aa_r   <= aa[60:0];
      s2_bb_r   <= bb[60:0];
      s2_ca_r   <= ca;
      s2_db_r   <= db;
      s2_ball_r <= s1_ball_r;
    end
  end

  // stage 3: squared length and dot product
  logic [LEN_W-1:0]   s3_len_r;
  logic signed [62:0] s3_dot_r;
  ball_t              s3_ball_r;
  logic               s3_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_len_r  <= {1'b0, s2_aa_r} + {1'b0, s2_bb_r};
      s3_dot_r  <= {s2_ca_r[61], s2_ca_r} + {s2_db_r[61], s2_db_r};
      s3_ball_r <= s2_ball_r;
    end
  end

  // stage 4: clamp decisions and divider entry
  logic [LEN_W-1:0]     dv_rem_r  [0:FRAC_BITS];
  logic [LEN_W-1:0]     dv_len_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_r    [0:FRAC_BITS];
  proj_flag_t           dv_flag_r [0:FRAC_BITS];
  ball_t                dv_ball_r [0:FRAC_BITS];
  logic                 dv_vld_r  [0:FRAC_BITS];
  proj_flag_t           flag_nxt;

  always_comb begin
    flag_nxt.short_seg = s3_len_r < SEG_EPS;
    flag_nxt.t_zero    = s3_dot_r[62] || (s3_dot_r == '0);
    flag_nxt.t_one     = !s3_dot_r[62] && (s3_dot_r[61:0] >= s3_len_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= s3_dot_r[61:0];
      dv_len_r[0]  <= s3_len_r;
      dv_q_r[0]    <= '0;
      dv_flag_r[0] <= flag_nxt;
      dv_ball_r[0] <= s3_ball_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= vld_i;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      dv_vld_r[0] <= s3_vld_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [LEN_W:0] sh;
    logic [LEN_W:0] diff;
    logic           ge;

    assign sh   = {dv_rem_r[i], 1'b0};
    assign diff = sh - {1'b0, dv_len_r[i]};
    assign ge   = sh >= {1'b0, dv_len_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[i+1]  <= ge ? diff[LEN_W-1:0] : sh[LEN_W-1:0];
        dv_q_r[i+1]    <= {dv_q_r[i][FRAC_BITS-2:0], ge};
        dv_len_r[i+1]  <= dv_len_r[i];
        dv_flag_r[i+1] <= dv_flag_r[i];
        dv_ball_r[i+1] <= dv_ball_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[i+1] <= dv_vld_r[i];
      end
    end
  end

  // clamped parameter
  always_comb begin
    if (dv_flag_r[FRAC_BITS].t_one) begin
      t_o = {1'b1, {FRAC_BITS{1'b0}}};
    end else if (dv_flag_r[FRAC_BITS].t_zero) begin
      t_o = '0;
    end else begin
      t_o = {1'b0, dv_q_r[FRAC_BITS]};
    end
  end

  assign short_o = dv_flag_r[FRAC_BITS].short_seg;
  assign ball_o  = dv_ball_r[FRAC_BITS];
  assign vld_o   = dv_vld_r[FRAC_BITS];

endmodule

`default_nettype wire

/* rtl/core/cscr_hit.sv */
// contact point, overlap test and pipelined integer square root for the depth
// uses cscr_pkg
`default_nettype none

module cscr_hit #(
  parameter int FRAC_BITS = cscr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  cscr_pkg::ball_t    ball_i,
  input  logic [FRAC_BITS:0] t_i,
  input  logic               short_i,
  input  cscr_pkg::cfg_t     cfg_i,
  output logic               vld_o,
  output cscr_pkg::ball_t    ball_o,
  output cscr_pkg::contact_t contact_o
);
  import cscr_pkg::*;

  localparam int PW = FRAC_BITS + 35;
  localparam logic [27:0] DIST_EPS = 28'((64'd1 << FRAC_BITS) / 64'd10000);

  // stage 1: t times segment vector
  logic signed [32:0]   sx, sy;
  logic signed [PW-1:0] prx, pry;
  logic signed [PW-1:0] h1_prx_r, h1_pry_r;
  logic                 h1_short_r;
  ball_t                h1_ball_r;
  logic                 h1_vld_r;

  assign sx  = {cfg_i.end_x[31], cfg_i.end_x} - {cfg_i.start_x[31], cfg_i.start_x};
  assign sy  = {cfg_i.end_y[31], cfg_i.end_y} - {cfg_i.start_y[31], cfg_i.start_y};
  assign prx = $signed({1'b0, t_i}) * sx;
  assign pry = $signed({1'b0, t_i}) * sy;

  always_ff @(posedge clk) begin
    if (en) begin
      h1_prx_r   <= prx;
      h1_pry_r   <= pry;
      h1_short_r <= short_i;
      h1_ball_r  <= ball_i;
    end
  end

  // stage 2: contact point and offset from it
  logic signed [34:0] cxw, cyw;
  logic signed [35:0] ddx, ddy;
  logic signed [31:0] h2_cx_r, h2_cy_r;
  logic signed [35:0] h2_ddx_r, h2_ddy_r;
  ball_t              h2_ball_r;
  logic               h2_vld_r;

  always_comb begin
    if (h1_short_r) begin
      cxw = {{3{cfg_i.start_x[31]}}, cfg_i.start_x};
      cyw = {{3{cfg_i.start_y[31]}}, cfg_i.start_y};
    end else begin
      cxw = {{3{cfg_i.start_x[31]}}, cfg_i.start_x} + $signed(h1_prx_r[PW-1:FRAC_BITS]);
      cyw = {{3{cfg_i.start_y[31]}}, cfg_i.start_y} + $signed(h1_pry_r[PW-1:FRAC_BITS]);
    end
    ddx = {{4{h1_ball_r.pos_x[31]}}, h1_ball_r.pos_x} - {cxw[34], cxw};
    ddy = {{4{h1_ball_r.pos_y[31]}}, h1_ball_r.pos_y} - {cyw[34], cyw};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_cx_r   <= sat32(SAT_W'(cxw));
      h2_cy_r   <= sat32(SAT_W'(cyw));
      h2_ddx_r  <= ddx;
      h2_ddy_r  <= ddy;
      h2_ball_r <= h1_ball_r;
    end
  end

  // stage 3: range check and squares
  logic signed [27:0] dx28, dy28;
  logic signed [55:0] sqx, sqy;
  logic [53:0]        rr;
  logic               in_range;
  logic [53:0]        h3_sqx_r, h3_sqy_r, h3_rr_r;
  logic               h3_inr_r;
  logic signed [31:0] h3_cx_r, h3_cy_r;
  ball_t              h3_ball_r;
  logic               h3_vld_r;

  assign dx28 = h2_ddx_r[27:0];
  assign dy28 = h2_ddy_r[27:0];
  assign sqx  = dx28 * dx28;
  assign sqy  = dy28 * dy28;
  assign rr   = h2_ball_r.radius * h2_ball_r.radius;
  assign in_range = (h2_ddx_r < 36'sd134217728) && (h2_ddx_r > -36'sd134217728) &&
                    (h2_ddy_r < 36'sd134217728) && (h2_ddy_r > -36'sd134217728);

  always_ff @(posedge clk) begin
    if (en) begin
      h3_sqx_r  <= sqx[53:0];
      h3_sqy_r  <= sqy[53:0];
      h3_rr_r   <= rr;
      h3_inr_r  <= in_range;
      h3_cx_r   <= h2_cx_r;
      h3_cy_r   <= h2_cy_r;
      h3_ball_r <= h2_ball_r;
    end
  end

  // stage 4: squared distance and overlap decision, square root entry
  logic [DSQ_W-1:0] dsq;
  logic [DSQ_W-1:0] sq_v_r   [0:SQRT_STEPS];
  logic [DSQ_W-1:0] sq_res_r [0:SQRT_STEPS];
  contact_t         sq_c_r   [0:SQRT_STEPS];
  ball_t            sq_ball_r[0:SQRT_STEPS];
  logic             sq_vld_r [0:SQRT_STEPS];
  contact_t         c_nxt;

  assign dsq = {1'b0, h3_sqx_r} + {1'b0, h3_sqy_r};

  always_comb begin
    c_nxt.hit = h3_inr_r && (dsq < {1'b0, h3_rr_r});
    c_nxt.pen = '0;
    c_nxt.cx  = h3_cx_r;
    c_nxt.cy  = h3_cy_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v_r[0]    <= dsq;
      sq_res_r[0]  <= '0;
      sq_c_r[0]    <= c_nxt;
      sq_ball_r[0] <= h3_ball_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r    <= 1'b0;
      h2_vld_r    <= 1'b0;
      h3_vld_r    <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      h1_vld_r    <= vld_i;
      h2_vld_r    <= h1_vld_r;
      h3_vld_r    <= h2_vld_r;
      sq_vld_r[0] <= h3_vld_r;
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [DSQ_W-1:0] STEP_BIT = DSQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [DSQ_W-1:0] trial;
    logic             ge;

    assign trial = sq_res_r[j] + STEP_BIT;
    assign ge    = sq_v_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_v_r[j+1]    <= ge ? (sq_v_r[j] - trial) : sq_v_r[j];
        sq_res_r[j+1]  <= ge ? ((sq_res_r[j] >> 1) + STEP_BIT) : (sq_res_r[j] >> 1);
        sq_c_r[j+1]    <= sq_c_r[j];
        sq_ball_r[j+1] <= sq_ball_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[j+1] <= sq_vld_r[j];
      end
    end
  end

  // penetration depth, full radius when the centre sits on the segment
  logic [27:0] sq_root;
  logic [26:0] rad;

  assign sq_root = sq_res_r[SQRT_STEPS][27:0];
  assign rad     = sq_ball_r[SQRT_STEPS].radius;

  always_comb begin
    contact_o = sq_c_r[SQRT_STEPS];
    if (!sq_c_r[SQRT_STEPS].hit) begin
      contact_o.pen = '0;
    end else if (sq_root < DIST_EPS) begin
      contact_o.pen = rad;
    end else begin
      contact_o.pen = rad - sq_root[26:0];
    end
  end

  assign ball_o = sq_ball_r[SQRT_STEPS];
  assign vld_o  = sq_vld_r[SQRT_STEPS];

endmodule

`default_nettype wire

/* rtl/core/cscr_resp.sv */
// collision response: push-out along the upward normal, bounce and slide assist
// uses cscr_pkg
`default_nettype none

module cscr_resp #(
  parameter int FRAC_BITS = cscr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  cscr_pkg::ball_t    ball_i,
  input  cscr_pkg::contact_t contact_i,
  input  cscr_pkg::cfg_t     cfg_i,
  output logic               vld_o,
  output cscr_pkg::result_t  res_o
);
  import cscr_pkg::*;

  localparam int DNW = 52 - FRAC_BITS;
  localparam int FW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int BDW = FW + DNW - FRAC_BITS;

  // upward normal from the tangent
  logic signed [18:0] tx19, ty19, nx, ny;

  assign tx19 = {cfg_i.tan_x[17], cfg_i.tan_x};
  assign ty19 = {cfg_i.tan_y[17], cfg_i.tan_y};

  always_comb begin
    if (cfg_i.tan_x > 18'sd0) begin
      nx = ty19;
      ny = -tx19;
    end else begin
      nx = -ty19;
      ny = tx19;
    end
  end

  // stage 1: normal times depth, velocity times normal
  logic signed [27:0] pen28;
  logic signed [46:0] pnx, pny;
  logic signed [50:0] dvx, dvy;
  logic signed [46:0] r1_pnx_r, r1_pny_r;
  logic signed [50:0] r1_dvx_r, r1_dvy_r;
  contact_t           r1_c_r;
  ball_t              r1_ball_r;
  logic               r1_vld_r;

  assign pen28 = {1'b0, contact_i.pen};
  assign pnx   = nx * pen28;
  assign pny   = ny * pen28;
  assign dvx   = ball_i.vel_x * nx;
  assign dvy   = ball_i.vel_y * ny;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_pnx_r  <= pnx;
      r1_pny_r  <= pny;
      r1_dvx_r  <= dvx;
      r1_dvy_r  <= dvy;
      r1_c_r    <= contact_i;
      r1_ball_r <= ball_i;
    end
  end

  // stage 2: pushed-out position, normal speed
  logic signed [51:0]    dotn;
  logic signed [31:0]    r2_npx_r, r2_npy_r;
  logic signed [DNW-1:0] r2_dn_r;
  logic                  r2_neg_r;
  contact_t              r2_c_r;
  ball_t                 r2_ball_r;
  logic                  r2_vld_r;

  assign dotn = {r1_dvx_r[50], r1_dvx_r} + {r1_dvy_r[50], r1_dvy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      r2_npx_r  <= sat32(SAT_W'(r1_ball_r.pos_x) + (SAT_W'(r1_pnx_r) >>> FRAC_BITS));
      r2_npy_r  <= sat32(SAT_W'(r1_ball_r.pos_y) + (SAT_W'(r1_pny_r) >>> FRAC_BITS));
      r2_dn_r   <= dotn[51:FRAC_BITS];
      r2_neg_r  <= dotn[51];
      r2_c_r    <= r1_c_r;
      r2_ball_r <= r1_ball_r;
    end
  end

  // stage 3: bounce scale and slide terms
  logic signed [FW-1:0]     fac;
  logic signed [FW+DNW-1:0] bdp;
  logic signed [45:0]       ax, ay;
  logic signed [BDW-1:0]    r3_bd_r;
  logic signed [45:0]       r3_ax_r, r3_ay_r;
  logic signed [31:0]       r3_npx_r, r3_npy_r;
  logic                     r3_neg_r;
  contact_t                 r3_c_r;
  ball_t                    r3_ball_r;
  logic                     r3_vld_r;

  assign fac = $signed(FW'((64'd1 << FRAC_BITS) + 64'(cfg_i.restitution)));
  assign bdp = fac * r2_dn_r;
  assign ax  = cfg_i.tan_x * $signed({1'b0, cfg_i.slide_assist});
  assign ay  = cfg_i.tan_y * $signed({1'b0, cfg_i.slide_assist});

  always_ff @(posedge clk) begin
    if (en) begin
      r3_bd_r   <= bdp[FW+DNW-1:FRAC_BITS];
      r3_ax_r   <= ax;
      r3_ay_r   <= ay;
      r3_npx_r  <= r2_npx_r;
      r3_npy_r  <= r2_npy_r;
      r3_neg_r  <= r2_neg_r;
      r3_c_r    <= r2_c_r;
      r3_ball_r <= r2_ball_r;
    end
  end

  // stage 4: bounce along the normal
  logic signed [BDW+18:0] bnx, bny;
  logic signed [BDW+18:0] r4_bnx_r, r4_bny_r;
  logic signed [45:0]     r4_ax_r, r4_ay_r;
  logic signed [31:0]     r4_npx_r, r4_npy_r;
  logic                   r4_neg_r;
  contact_t               r4_c_r;
  ball_t                  r4_ball_r;
  logic                   r4_vld_r;

  assign bnx = r3_bd_r * nx;
  assign bny = r3_bd_r * ny;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_bnx_r  <= bnx;
      r4_bny_r  <= bny;
      r4_ax_r   <= r3_ax_r;
      r4_ay_r   <= r3_ay_r;
      r4_npx_r  <= r3_npx_r;
      r4_npy_r  <= r3_npy_r;
      r4_neg_r  <= r3_neg_r;
      r4_c_r    <= r3_c_r;
      r4_ball_r <= r3_ball_r;
    end
  end

  // stage 5: resolved velocity, only when moving into the ramp
  result_t res_nxt;
  result_t r5_res_r;
  logic    r5_vld_r;

  always_comb begin
    res_nxt.c         = r4_c_r;
    res_nxt.new_pos_x = r4_npx_r;
    res_nxt.new_pos_y = r4_npy_r;
    if (r4_c_r.hit && r4_neg_r) begin
      res_nxt.new_vel_x = sat32(SAT_W'(r4_ball_r.vel_x) - (SAT_W'(r4_bnx_r) >>> FRAC_BITS)
                                + (SAT_W'(r4_ax_r) >>> FRAC_BITS));
      res_nxt.new_vel_y = sat32(SAT_W'(r4_ball_r.vel_y) - (SAT_W'(r4_bny_r) >>> FRAC_BITS)
                                + (SAT_W'(r4_ay_r) >>> FRAC_BITS));
    end else begin
      res_nxt.new_vel_x = r4_ball_r.vel_x;
      res_nxt.new_vel_y = r4_ball_r.vel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_res_r <= res_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
      r3_vld_r <= 1'b0;
      r4_vld_r <= 1'b0;
      r5_vld_r <= 1'b0;
    end else if (en) begin
      r1_vld_r <= vld_i;
      r2_vld_r <= r1_vld_r;
      r3_vld_r <= r2_vld_r;
      r4_vld_r <= r3_vld_r;
      r5_vld_r <= r4_vld_r;
    end
  end

  assign res_o = r5_res_r;
  assign vld_o = r5_vld_r;

endmodule

`default_nettype wire

/* rtl/core/circle_segment_collide_resolve_top.sv */
// ball against ramp segment: collision test and response, fully pipelined
//
// in_ channel: one ball per item (centre, velocity, radius). out_ channel: one
// result per item, in order: hit flag on out_tuser, depth, contact point,
// resolved position and velocity on out_tdata. cfg_ port writes the segment,
// tangent, restitution and slide assist registers; write only while idle.
// pipeline from acceptance to out_tvalid: four projection stages, one divider
// stage per fraction bit, four contact stages, 27 square root stages, five
// response stages and the output register. throughput: one item per cycle
// while the receiver does not stall, set by the fully pipelined divider and
// square root.
// reset (synchronous, active low) empties the pipeline and loads the register
// defaults (tangent 1.0 along x, everything else zero).
// when the receiver stalls, the output register holds its item and a skid
// register takes the next finished one; only then does the whole pipeline
// freeze and in_tready drop. nothing is lost or repeated.
`default_nettype none
`include "circle_segment_collide_resolve_top_assert.svh"

module circle_segment_collide_resolve_top #(
  parameter int FRAC_BITS = cscr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pos_x, pos_y, vel_x, vel_y, ball_radius, zero fill
  input  logic [159:0]                      in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // penetration_depth, contact_pt_x, contact_pt_y, new_pos_x, new_pos_y,
  // new_vel_x, new_vel_y, zero fill
  output logic [223:0]                      out_tdata,
  // hit
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [cscr_pkg::REG_IDX_W-1:0]    cfg_idx,
  input  logic [cscr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cscr_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x      <= '0;
      cfg_r.start_y      <= '0;
      cfg_r.end_x        <= '0;
      cfg_r.end_y        <= '0;
      cfg_r.tan_x        <= TAN_X_RST;
      cfg_r.tan_y        <= '0;
      cfg_r.restitution  <= '0;
      cfg_r.slide_assist <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START_X:      cfg_r.start_x      <= cfg_wdata;
        REG_START_Y:      cfg_r.start_y      <= cfg_wdata;
        REG_END_X:        cfg_r.end_x        <= cfg_wdata;
        REG_END_Y:        cfg_r.end_y        <= cfg_wdata;
        REG_TANGENT_X:    cfg_r.tan_x        <= cfg_wdata[17:0];
        REG_TANGENT_Y:    cfg_r.tan_y        <= cfg_wdata[17:0];
        REG_RESTITUTION:  cfg_r.restitution  <= cfg_wdata[16:0];
        REG_SLIDE_ASSIST: cfg_r.slide_assist <= cfg_wdata[26:0];
      endcase
    end
  end

  // input unpacking and pipeline advance
  ball_t ball_in;
  logic  skid_vld_r;
  logic  en;

  assign ball_in.pos_x  = in_tdata[31:0];
  assign ball_in.pos_y  = in_tdata[63:32];
  assign ball_in.vel_x  = in_tdata[95:64];
  assign ball_in.vel_y  = in_tdata[127:96];
  assign ball_in.radius = in_tdata[154:128];

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // projection and divider
  logic               p_vld;
  ball_t              p_ball;
  logic [FRAC_BITS:0] p_t;
  logic               p_short;

  cscr_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_tvalid),
    .ball_i  (ball_in),
    .cfg_i   (cfg_r),
    .vld_o   (p_vld),
    .ball_o  (p_ball),
    .t_o     (p_t),
    .short_o (p_short)
  );

  // contact, overlap and depth
  logic     h_vld;
  ball_t    h_ball;
  contact_t h_contact;

  cscr_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (p_vld),
    .ball_i    (p_ball),
    .t_i       (p_t),
    .short_i   (p_short),
    .cfg_i     (cfg_r),
    .vld_o     (h_vld),
    .ball_o    (h_ball),
    .contact_o (h_contact)
  );

  // response
  logic    r_vld;
  result_t r_res;

  cscr_resp #(.FRAC_BITS(FRAC_BITS)) u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (h_vld),
    .ball_i    (h_ball),
    .contact_i (h_contact),
    .cfg_i     (cfg_r),
    .vld_o     (r_vld),
    .res_o     (r_res)
  );

  // output register and skid register
  result_t out_r, skid_r;
  logic    out_vld_r;
  logic    out_load;

  assign out_load = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r  <= skid_vld_r || r_vld;
      skid_vld_r <= 1'b0;
    end else if (en && r_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_vld_r ? skid_r : r_res;
    end else if (en && r_vld) begin
      skid_r <= r_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.c.hit;
  assign out_tdata  = {5'b0, out_r.new_vel_y, out_r.new_vel_x, out_r.new_pos_y,
                       out_r.new_pos_x, out_r.c.cy, out_r.c.cx, out_r.c.pen};

  // checks
  `CSCR_ASSERT_SAME(a_skid_needs_out, skid_vld_r, out_vld_r, "skid full with empty output")
  `CSCR_ASSERT_SAME(a_no_hit_no_depth, out_vld_r && !out_r.c.hit, out_r.c.pen == '0, "depth without hit")
  `CSCR_ASSERT_NEXT(a_skid_holds, skid_vld_r && !out_tready, skid_vld_r, "skid item dropped under stall")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for circle_segment_collide_resolve_top: random and directed balls against
// several ramp settings, results predicted in-line and checked in order
// depends on cscr_pkg and the top level RTL
`default_nettype none

module testbench;
  import cscr_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 41;

  typedef struct {
    logic        hit;
    logic [26:0] depth;
    logic [31:0] cpx, cpy, npx, npy, nvx, nvy;
  } collision_t;

  // ramp registers as the predictor sees them
  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic signed [17:0] tx, ty;
    logic [16:0]        rest;
    logic [26:0]        assist;
  } ramp_t;

  // floor shift of a wide signed value
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // collision prediction for one ball
  function automatic collision_t predict_collision(ramp_t rp, logic [31:0] px_i,
      logic [31:0] py_i, logic [31:0] vx_i, logic [31:0] vy_i, logic [26:0] r_i);
    longint px, py, vx, vy, r, x1, y1, sgx, sgy, a, b, c, d, len, cx, cy;
    longint dot, t, ddx, ddy, pen, nx, ny, npx, npy, nvx, nvy, dotn, dn, bd;
    longint unsigned rem, q, dsq, root;
    logic hit;
    collision_t res;
    px = longint'($signed(px_i)); py = longint'($signed(py_i));
    vx = longint'($signed(vx_i)); vy = longint'($signed(vy_i));
    r = longint'(r_i);
    x1 = longint'(rp.sx); y1 = longint'(rp.sy);
    sgx = longint'(rp.ex) - x1; sgy = longint'(rp.ey) - y1;
    a = floor_shr(sgx, 2); b = floor_shr(sgy, 2);
    c = floor_shr(px - x1, 2); d = floor_shr(py - y1, 2);
    len = a * a + b * b;
    cx = x1; cy = y1;
    pen = 0; hit = 0;
    npx = px; npy = py; nvx = vx; nvy = vy;
    // projection, skipped for a very short segment
    if (len >= ((64'd1 << (2 * FB - 4)) / 10000)) begin
      dot = c * a + d * b;
      if (dot <= 0) t = 0;
      else if (dot >= len) t = 64'sd1 << FB;
      else begin
        rem = dot; q = 0;
        for (int i = 0; i < FB; i++) begin
          rem <<= 1; q <<= 1;
          if (rem >= len) begin
            rem -= len; q |= 1;
          end
        end
        t = q;
      end
      cx = x1 + floor_shr(t * sgx, FB);
      cy = y1 + floor_shr(t * sgy, FB);
    end
    // overlap test
    ddx = px - cx; ddy = py - cy;
    if (ddx < (64'sd1 << 27) && ddx > -(64'sd1 << 27) &&
        ddy < (64'sd1 << 27) && ddy > -(64'sd1 << 27)) begin
      dsq = ddx * ddx + ddy * ddy;
      if (dsq < r * r) begin
        root = int_sqrt(dsq);
        hit = 1;
        pen = (root < ((64'd1 << FB) / 10000)) ? r : r - longint'(root);
      end
    end
    // response along the upward normal
    if (hit) begin
      nx = -longint'(rp.ty); ny = longint'(rp.tx);
      if (ny > 0) begin
        nx = -nx; ny = -ny;
      end
      npx = px + floor_shr(nx * pen, FB);
      npy = py + floor_shr(ny * pen, FB);
      dotn = vx * nx + vy * ny;
      if (dotn < 0) begin
        dn = floor_shr(dotn, FB);
        bd = floor_shr(((64'sd1 << FB) + longint'(rp.rest)) * dn, FB);
        nvx = vx - floor_shr(bd * nx, FB) + floor_shr(longint'(rp.tx) * longint'(rp.assist), FB);
        nvy = vy - floor_shr(bd * ny, FB) + floor_shr(longint'(rp.ty) * longint'(rp.assist), FB);
      end
    end
    res.hit = hit; res.depth = pen[26:0];
    res.cpx = 32'(clamp32(cx)); res.cpy = 32'(clamp32(cy));
    res.npx = 32'(clamp32(npx)); res.npy = 32'(clamp32(npy));
    res.nvx = 32'(clamp32(nvx)); res.nvy = 32'(clamp32(nvy));
    return res;
  endfunction

  // in-order store of predicted collisions
  class collision_scoreboard;
    collision_t pending[$];
    int errors;

    function void note_ball(ramp_t rp, logic [159:0] ball);
      pending.push_back(predict_collision(rp, ball[31:0], ball[63:32], ball[95:64],
                                          ball[127:96], ball[154:128]));
    endfunction

    function void check_result(logic hit, logic [223:0] dat);
      collision_t e;
      if (pending.size() == 0) begin
        $error("result with no ball waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, hit); errors++;
      end
      if (dat[26:0] !== e.depth) begin
        $error("penetration_depth exp %0d got %0d", e.depth, dat[26:0]); errors++;
      end
      if (dat[58:27] !== e.cpx) begin
        $error("contact_pt_x exp %h got %h", e.cpx, dat[58:27]); errors++;
      end
      if (dat[90:59] !== e.cpy) begin
        $error("contact_pt_y exp %h got %h", e.cpy, dat[90:59]); errors++;
      end
      if (dat[122:91] !== e.npx) begin
        $error("new_pos_x exp %h got %h", e.npx, dat[122:91]); errors++;
      end
      if (dat[154:123] !== e.npy) begin
        $error("new_pos_y exp %h got %h", e.npy, dat[154:123]); errors++;
      end
      if (dat[186:155] !== e.nvx) begin
        $error("new_vel_x exp %h got %h", e.nvx, dat[186:155]); errors++;
      end
      if (dat[218:187] !== e.nvy) begin
        $error("new_vel_y exp %h got %h", e.nvy, dat[218:187]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic [159:0] in_tdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [223:0] out_tdata;
  logic out_tuser, out_tvalid;
  logic out_tready = 0;
  logic cfg_we = 0;
  logic [REG_IDX_W-1:0] cfg_idx = REG_START_X;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  collision_scoreboard sb = new();
  ramp_t ramp;
  bit stim_done = 0;

  always #10 clk = ~clk;

  circle_segment_collide_resolve_top uut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tuser,
    .out_tvalid, .out_tready, .cfg_we, .cfg_idx, .cfg_wdata
  );

  // result side: random stalls, check each accepted item
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
      sb.check_result(out_tuser, out_tdata);
    end
  end

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_START_X: ramp.sx = val;
      REG_START_Y: ramp.sy = val;
      REG_END_X: ramp.ex = val;
      REG_END_Y: ramp.ey = val;
      REG_TANGENT_X: ramp.tx = val[17:0];
      REG_TANGENT_Y: ramp.ty = val[17:0];
      REG_RESTITUTION: ramp.rest = val[16:0];
      default: ramp.assist = val[26:0];
    endcase
  endtask

  task automatic set_ramp(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
      logic [31:0] ey, logic [31:0] tx, logic [31:0] ty, logic [31:0] rest,
      logic [31:0] assist);
    write_reg(REG_START_X, sx); write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex); write_reg(REG_END_Y, ey);
    write_reg(REG_TANGENT_X, tx); write_reg(REG_TANGENT_Y, ty);
    write_reg(REG_RESTITUTION, rest); write_reg(REG_SLIDE_ASSIST, assist);
    cfg_we <= 0;
  endtask

  // wait until nothing is in flight
  task automatic drain();
    wait (sb.pending.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one ball with a random lead-in gap; valid stays high over back-to-back items
  task automatic send_ball(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
      logic [31:0] vy, logic [26:0] r);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {5'd0, r, vy, vx, py, px};
    in_tvalid <= 1;
    @(posedge clk iff in_tready);
    sb.note_ball(ramp, {5'd0, r, vy, vx, py, px});
  endtask

  task automatic end_burst();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // ball near the segment, random content
  task automatic near_ball();
    longint fx, fy, t;
    logic [26:0] r;
    t = $urandom_range(0, 1 << 12);
    fx = ramp.sx + (((longint'(ramp.ex) - ramp.sx) * t) >>> 12);
    fy = ramp.sy + (((longint'(ramp.ey) - ramp.sy) * t) >>> 12);
    r = ($urandom_range(0, 9) == 0) ? 27'($urandom()) : 27'($urandom_range(0, 1 << 22));
    fx += $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    fy += $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    send_ball(32'(clamp32(fx)), 32'(clamp32(fy)), $urandom(),
              ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20), r);
  endtask

  // stimulus
  initial begin
    ramp.sx = 0; ramp.sy = 0; ramp.ex = 0; ramp.ey = 0;
    ramp.tx = 18'sd65536; ramp.ty = 0; ramp.rest = 0; ramp.assist = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: zero-length segment at the origin
    send_ball(0, 0, 0, 32'h0001_0000, 27'h1_0000);
    send_ball(32'h0000_8000, 0, 0, 0, 27'h1_0000);
    end_burst();
    drain();

    // flat ramp, full bounce and assist
    set_ramp(32'hFFF6_0000, 0, 32'h000A_0000, 0, 65536, 0, 65536, 32'h400_0000);
    send_ball(0, 0, 0, 32'h0002_0000, 27'h1_0000);           // centre on the line
    send_ball(0, 32'hFFFF_8000, 0, 32'h0002_0000, 27'h1_0000); // moving into ramp
    send_ball(0, 32'hFFFF_8000, 0, 32'hFFFE_0000, 27'h1_0000); // moving away
    send_ball(32'hFFE0_0000, 0, 0, 0, 27'h2_0000);            // beyond start, t=0
    send_ball(32'h0020_0000, 0, 0, 0, 27'h2_0000);            // beyond end, t=1
    send_ball(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 27'h7FF_FFFF);
    send_ball(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 27'h7FF_FFFF);
    send_ball(0, 32'hFFFF_0000, 0, 0, 27'h1_0000);            // touching, no hit
    send_ball(0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0);          // zero radius
    send_ball(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 27'h400_0000);
    end_burst();
    drain();

    // extreme segment and odd tangent
    set_ramp(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0002_0000, 32'h0001_0000, 0, 0);
    send_ball(0, 0, 32'h8000_0000, 32'h8000_0000, 27'h7FF_FFFF);
    send_ball(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 27'h7FF_FFFF);
    send_ball(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 27'h400_0000);
    end_burst();
    drain();

    // random phases, each with a new ramp
    for (int ph = 0; ph < 6; ph++) begin
      longint len, ang;
      logic [31:0] sx, sy;
      sx = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      sy = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      len = (ph == 5) ? 0 : $urandom_range(0, 1 << 25);
      ang = $urandom_range(0, 1 << 17);
      set_ramp(sx, sy, 32'(sx + len), 32'(sy + (($signed(ang) - 65536) * len >>> 17)),
               ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 1 << 17) - 65536,
               $urandom_range(0, 1 << 17) - 65536,
               (ph == 0) ? 0 : (ph == 1) ? 65536 : $urandom(),
               (ph == 0) ? 0 : (ph == 1) ? 32'h400_0000 : $urandom());
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_ball($urandom(), $urandom(), $urandom(), $urandom(), 27'($urandom()));
        else
          near_ball();
        // hold back until everything has drained once per phase
        if (i == 45) begin
          end_burst();
          wait (sb.pending.size() == 0);
        end
      end
      end_burst();
      drain();
    end
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    if (sb.errors == 0)
      $display("circle_segment_collide_resolve_top test passed");
    else
      $display("circle_segment_collide_resolve_top test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("circle_segment_collide_resolve_top test failed");
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/cscr_pkg.sv
rtl/core/cscr_proj.sv
rtl/core/cscr_hit.sv
rtl/core/cscr_resp.sv
rtl/core/circle_segment_collide_resolve_top.sv
tb/testbench.sv
